FILE: rtl/baide_pkg.sv
`timescale 1ns / 1ps

package baide_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 6;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_POP    = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_FIND   = 3'd5,
    CMD_READ   = 3'd6
  } cmd_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  typedef enum logic [1:0] {
    SC_INS  = 2'd0,
    SC_DEL  = 2'd1,
    SC_REM  = 2'd2,
    SC_FIND = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic       go;
    scan_mode_t mode;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_sts_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_READ = 5'b01000,
    ST_POST = 5'b10000
  } state_t;

endpackage

FILE: rtl/bounded_array_insert_delete_engine.sv
`timescale 1ns / 1ps

// Channel  Handshake           Transfer at rising edge     Payload
// in_      start / busy        start && !busy              in_command, in_position_in, in_item
// out_     out_valid strobe    every cycle out_valid high  out_data_out .. out_status
//
// Push, unused codes and rejected commands finish in ST_EXEC; pop and read add ST_READ.
// Insert, delete, remove and find walk the array through one RAM read port and
// one write port, one entry per cycle.
// Reset clears the fill count and the sequencer; the entry RAM is not cleared.
// The receiver cannot stall: each result is shown for one cycle only.

module bounded_array_insert_delete_engine
  import baide_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 in_command,
  input  logic [POS_W-1:0]           in_position_in,
  input  logic signed [WORD_W-1:0]   in_item,
  output logic                       out_valid,
  output logic signed [WORD_W-1:0]   out_data_out,
  output logic [POS_W-1:0]           out_position_out,
  output logic                       out_found,
  output logic [$clog2(DEPTH+1)-1:0] out_fill_count,
  output logic                       out_is_empty,
  output logic [1:0]                 out_status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [POS_W-1:0]  pos_r;
  logic [WORD_W-1:0] item_r;
  logic [CW-1:0]     count_r, count_nxt;

  logic              valid_r;
  logic [WORD_W-1:0] data_r;
  logic [POS_W-1:0]  where_r;
  logic              found_r;
  logic [CW-1:0]     fill_r;
  logic              empty_r;
  logic [1:0]        status_r;

  logic              fin;
  logic [WORD_W-1:0] res_data;
  logic [POS_W-1:0]  res_pos;
  logic              res_found;
  logic [1:0]        res_status;

  logic [XW-1:0]     pos_x, cnt_x;
  logic [CW-1:0]     cnt_m1;
  logic              full;

  logic              top_we;
  logic [AW-1:0]     top_waddr, top_raddr;
  scan_req_t         req;
  scan_sts_t         sts;
  logic [CW-1:0]     rd_start, n_reads, wr_start, hit_idx, wr_end;

  logic              ram_we, scan_we;
  logic [AW-1:0]     ram_waddr, ram_raddr, scan_waddr, scan_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata, scan_wdata;

  assign pos_x  = XW'(pos_r);
  assign cnt_x  = XW'(count_r);
  assign cnt_m1 = count_r - 1'b1;
  assign full   = (count_r == CW'(DEPTH));
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    fin        = 1'b0;
    res_data   = '0;
    res_pos    = '0;
    res_found  = 1'b0;
    res_status = STAT_OK;
    top_we     = 1'b0;
    top_waddr  = count_r[AW-1:0];
    top_raddr  = '0;
    req.go     = 1'b0;
    req.mode   = SC_FIND;
    rd_start   = '0;
    n_reads    = '0;
    wr_start   = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        fin       = 1'b1;
        case (cmd_r)
          CMD_PUSH: begin
            if (full) begin
              res_status = STAT_FULL;
            end else begin
              top_we    = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          CMD_INSERT: begin
            if (full) begin
              res_status = STAT_FULL;
            end else if (pos_x > cnt_x) begin
              res_status = STAT_RANGE;
            end else begin
              fin       = 1'b0;
              state_nxt = ST_SCAN;
              req.go    = 1'b1;
              req.mode  = SC_INS;
              rd_start  = cnt_m1;
              n_reads   = CW'(cnt_x - pos_x);
            end
          end
          CMD_POP: begin
            if (count_r == '0) begin
              res_status = STAT_EMPTY;
            end else begin
              fin       = 1'b0;
              state_nxt = ST_READ;
              top_raddr = cnt_m1[AW-1:0];
              count_nxt = cnt_m1;
            end
          end
          CMD_DELETE: begin
            if (count_r == '0) begin
              res_status = STAT_EMPTY;
            end else if (pos_x >= cnt_x) begin
              res_status = STAT_RANGE;
            end else begin
              fin       = 1'b0;
              state_nxt = ST_SCAN;
              req.go    = 1'b1;
              req.mode  = SC_DEL;
              rd_start  = CW'(pos_x + 1'b1);
              n_reads   = CW'(cnt_x - pos_x - 1'b1);
              wr_start  = CW'(pos_x);
            end
          end
          CMD_REMOVE, CMD_FIND: begin
            fin       = 1'b0;
            state_nxt = ST_SCAN;
            req.go    = 1'b1;
            req.mode  = (cmd_r == CMD_REMOVE) ? SC_REM : SC_FIND;
            n_reads   = count_r;
          end
          CMD_READ: begin
            if (pos_x >= cnt_x) begin
              res_status = STAT_RANGE;
            end else begin
              fin       = 1'b0;
              state_nxt = ST_READ;
              top_raddr = pos_x[AW-1:0];
            end
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        if (sts.done) begin
          state_nxt = ST_POST;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
        fin       = 1'b1;
        res_data  = ram_rdata;
      end
      ST_POST: begin
        state_nxt = ST_IDLE;
        fin       = 1'b1;
        case (cmd_r)
          CMD_INSERT: begin
            top_we    = 1'b1;
            top_waddr = pos_x[AW-1:0];
            count_nxt = count_r + 1'b1;
          end
          CMD_DELETE: begin
            count_nxt = cnt_m1;
          end
          CMD_REMOVE: begin
            count_nxt = wr_end;
          end
          CMD_FIND: begin
            res_found = sts.hit;
            if (sts.hit) begin
              res_pos = POS_W'(hit_idx);
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  baide_scan #(
    .DEPTH(DEPTH)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .rd_start (rd_start),
    .n_reads  (n_reads),
    .wr_start (wr_start),
    .key      (item_r),
    .mem_rdata(ram_rdata),
    .mem_raddr(scan_raddr),
    .mem_we   (scan_we),
    .mem_waddr(scan_waddr),
    .mem_wdata(scan_wdata),
    .sts      (sts),
    .hit_idx  (hit_idx),
    .wr_end   (wr_end)
  );

  assign ram_we    = top_we | scan_we;
  assign ram_waddr = top_we ? top_waddr : scan_waddr;
  assign ram_wdata = top_we ? item_r : scan_wdata;
  assign ram_raddr = (state_r == ST_SCAN) ? scan_raddr : top_raddr;

  baide_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r  <= cmd_t'(in_command);
      pos_r  <= in_position_in;
      item_r <= in_item;
    end
    if (fin) begin
      data_r   <= res_data;
      where_r  <= res_pos;
      found_r  <= res_found;
      fill_r   <= count_nxt;
      empty_r  <= (count_nxt == '0);
      status_r <= res_status;
    end
  end

  assign out_valid        = valid_r;
  assign out_data_out     = data_r;
  assign out_position_out = where_r;
  assign out_found        = found_r;
  assign out_fill_count   = fill_r;
  assign out_is_empty     = empty_r;
  assign out_status       = status_r;

endmodule

FILE: rtl/baide_ram.sv
`timescale 1ns / 1ps

module baide_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/baide_scan.sv
`timescale 1ns / 1ps

module baide_scan
  import baide_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  scan_req_t                  req,
  input  logic [$clog2(DEPTH+1)-1:0] rd_start,
  input  logic [$clog2(DEPTH+1)-1:0] n_reads,
  input  logic [$clog2(DEPTH+1)-1:0] wr_start,
  input  logic [WORD_W-1:0]          key,
  input  logic [WORD_W-1:0]          mem_rdata,
  output logic [$clog2(DEPTH)-1:0]   mem_raddr,
  output logic                       mem_we,
  output logic [$clog2(DEPTH)-1:0]   mem_waddr,
  output logic [WORD_W-1:0]          mem_wdata,
  output scan_sts_t                  sts,
  output logic [$clog2(DEPTH+1)-1:0] hit_idx,
  output logic [$clog2(DEPTH+1)-1:0] wr_end
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic              run_r, run_nxt;
  logic              pend_r, pend_nxt;
  logic              hit_r, hit_nxt;
  scan_mode_t        mode_r, mode_nxt;
  logic [CW-1:0]     rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]     left_r, left_nxt;
  logic [CW-1:0]     pend_addr_r, pend_addr_nxt;
  logic [CW-1:0]     wr_r, wr_nxt;
  logic [CW-1:0]     hit_idx_r, hit_idx_nxt;
  logic [WORD_W-1:0] key_r, key_nxt;
  logic              issue, eq, stop;
  logic [CW-1:0]     ins_addr;

  assign issue     = run_r && (left_r != '0);
  assign eq        = (mem_rdata == key_r);
  assign ins_addr  = pend_addr_r + 1'b1;
  assign mem_raddr = rd_addr_r[AW-1:0];
  assign mem_wdata = mem_rdata;
  assign hit_idx   = hit_idx_r;
  assign wr_end    = wr_r;

  always_comb begin
    run_nxt       = run_r;
    pend_nxt      = 1'b0;
    hit_nxt       = hit_r;
    mode_nxt      = mode_r;
    rd_addr_nxt   = rd_addr_r;
    left_nxt      = left_r;
    pend_addr_nxt = rd_addr_r;
    wr_nxt        = wr_r;
    hit_idx_nxt   = hit_idx_r;
    key_nxt       = key_r;
    mem_we        = 1'b0;
    mem_waddr     = wr_r[AW-1:0];
    stop          = 1'b0;
    sts.done      = 1'b0;
    sts.hit       = hit_r;
    if (req.go) begin
      run_nxt     = 1'b1;
      hit_nxt     = 1'b0;
      mode_nxt    = req.mode;
      rd_addr_nxt = rd_start;
      left_nxt    = n_reads;
      wr_nxt      = wr_start;
      key_nxt     = key;
    end else if (run_r) begin
      if (pend_r) begin
        case (mode_r)
          SC_INS: begin
            mem_we    = 1'b1;
            mem_waddr = ins_addr[AW-1:0];
          end
          SC_DEL: begin
            mem_we = 1'b1;
            wr_nxt = wr_r + 1'b1;
          end
          SC_REM: begin
            if (!eq) begin
              mem_we = 1'b1;
              wr_nxt = wr_r + 1'b1;
            end
          end
          SC_FIND: begin
            if (eq) begin
              stop        = 1'b1;
              hit_nxt     = 1'b1;
              hit_idx_nxt = pend_addr_r;
            end
          end
          default: begin
          end
        endcase
      end
      if (stop || (left_r == '0 && !pend_r)) begin
        run_nxt  = 1'b0;
        sts.done = 1'b1;
      end else if (issue) begin
        pend_nxt    = 1'b1;
        left_nxt    = left_r - 1'b1;
        rd_addr_nxt = (mode_r == SC_INS) ? rd_addr_r - 1'b1 : rd_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      pend_r <= 1'b0;
      hit_r  <= 1'b0;
      mode_r <= SC_FIND;
    end else begin
      run_r  <= run_nxt;
      pend_r <= pend_nxt;
      hit_r  <= hit_nxt;
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r   <= rd_addr_nxt;
    left_r      <= left_nxt;
    pend_addr_r <= pend_addr_nxt;
    wr_r        <= wr_nxt;
    hit_idx_r   <= hit_idx_nxt;
    key_r       <= key_nxt;
  end

endmodule
